>>> design/wfgdd_pkg.sv
// wfgdd_pkg: item types, kind codes, controller states and the
// command / status bundles shared by the wait-for graph deadlock detector
// no dependencies
package wfgdd_pkg;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] node;
        logic [4:0] target;
    } in_item_t;

    typedef struct packed {
        logic       deadlock;
        logic [1:0] done_kind;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_CHK_START,
        ST_LOAD,
        ST_EXPLORE,
        ST_POP_LOAD,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RD_NODE,
        RD_SWEEP,
        RD_NEXT
    } rd_src_t;

    typedef struct packed {
        logic    load_item;
        logic    add_wr;
        logic    rem_wr;
        logic    search_init;
        logic    load_top;
        logic    push;
        logic    skip;
        logic    pop;
        logic    pop_load;
        logic    set_found;
        logic    res_load;
        rd_src_t rd_src;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       node_ok;
        logic       target_ok;
        logic       self_edge;
        logic       sweep_last;
        logic       pend_zero;
        logic       depth_one;
        logic       v_on_stack;
        logic       v_visited;
        logic       out_free;
    } dp_status_t;

endpackage

>>> design/wfgdd_ctrl.sv
// wfgdd_ctrl: sequencer for add, remove, depth-first check and no-op items
// depends on wfgdd_pkg
module wfgdd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wfgdd_pkg::in_item_t   in_data,
    input  wfgdd_pkg::dp_status_t status,
    output wfgdd_pkg::dp_cmd_t    cmd
);

    wfgdd_pkg::state_t state_reg;
    wfgdd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfgdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = wfgdd_pkg::RD_NODE;
        in_ready   = 1'b0;
        unique case (state_reg)
            wfgdd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (in_data.kind)
                        wfgdd_pkg::KIND_ADD:    state_next = wfgdd_pkg::ST_ADD_RD;
                        wfgdd_pkg::KIND_REMOVE: state_next = wfgdd_pkg::ST_REM_RD;
                        wfgdd_pkg::KIND_CHECK:  state_next = wfgdd_pkg::ST_CHK_START;
                        default:                state_next = wfgdd_pkg::ST_RESP;
                    endcase
                end
            end
            wfgdd_pkg::ST_ADD_RD:
            begin
                cmd.rd_src = wfgdd_pkg::RD_NODE;
                state_next = wfgdd_pkg::ST_ADD_WR;
            end
            wfgdd_pkg::ST_ADD_WR:
            begin
                cmd.add_wr = status.node_ok && status.target_ok && !status.self_edge;
                state_next = wfgdd_pkg::ST_RESP;
            end
            wfgdd_pkg::ST_REM_RD:
            begin
                cmd.rd_src = wfgdd_pkg::RD_SWEEP;
                if (status.node_ok)
                begin
                    state_next = wfgdd_pkg::ST_REM_WR;
                end
                else
                begin
                    state_next = wfgdd_pkg::ST_RESP;
                end
            end
            wfgdd_pkg::ST_REM_WR:
            begin
                cmd.rem_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = wfgdd_pkg::ST_RESP;
                end
                else
                begin
                    state_next = wfgdd_pkg::ST_REM_RD;
                end
            end
            wfgdd_pkg::ST_CHK_START:
            begin
                cmd.rd_src = wfgdd_pkg::RD_NODE;
                if (status.node_ok)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = wfgdd_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = wfgdd_pkg::ST_RESP;
                end
            end
            wfgdd_pkg::ST_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = wfgdd_pkg::ST_EXPLORE;
            end
            wfgdd_pkg::ST_EXPLORE:
            begin
                cmd.rd_src = wfgdd_pkg::RD_NEXT;
                priority if (status.pend_zero)
                begin
                    cmd.pop = 1'b1;
                    if (status.depth_one)
                    begin
                        state_next = wfgdd_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = wfgdd_pkg::ST_POP_LOAD;
                    end
                end
                else if (status.v_on_stack)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = wfgdd_pkg::ST_RESP;
                end
                else if (status.v_visited)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = wfgdd_pkg::ST_LOAD;
                end
            end
            wfgdd_pkg::ST_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = wfgdd_pkg::ST_EXPLORE;
            end
            wfgdd_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = wfgdd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfgdd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/wfgdd_dp.sv
// wfgdd_dp: adjacency matrix memory, search stack memory, marks and
// the result register of the deadlock detector
// depends on wfgdd_pkg
module wfgdd_dp #(
    parameter int NUM_SLOTS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  wfgdd_pkg::in_item_t   in_data,
    input  logic                  out_ready,
    input  wfgdd_pkg::dp_cmd_t    cmd,
    output wfgdd_pkg::dp_status_t status,
    output logic                  out_valid,
    output wfgdd_pkg::out_item_t  out_data
);

    localparam int SLOT_W  = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int DEPTH_W = $clog2(NUM_SLOTS + 1);
    localparam logic [6:0] SLOTS_L = 7'(NUM_SLOTS);
    localparam logic [NUM_SLOTS-1:0] ONE_ROW = {{(NUM_SLOTS-1){1'b0}}, 1'b1};

    wfgdd_pkg::in_item_t  item_reg;
    wfgdd_pkg::out_item_t out_data_reg;
    logic                 out_valid_reg;
    logic                 found_reg;
    logic [SLOT_W-1:0]    sweep_reg;
    logic [NUM_SLOTS-1:0] visited_reg;
    logic [NUM_SLOTS-1:0] onstack_reg;
    logic [NUM_SLOTS-1:0] row_valid_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [SLOT_W-1:0]    cur_slot_reg;
    logic [NUM_SLOTS-1:0] cur_pend_reg;
    logic [SLOT_W-1:0]    rd_addr_reg;
    logic [NUM_SLOTS-1:0] mat_q_reg;
    logic                 mat_qv_reg;
    logic [SLOT_W-1:0]    stk_slot_q_reg;
    logic [NUM_SLOTS-1:0] stk_pend_q_reg;

    logic [NUM_SLOTS-1:0] mat_mem      [NUM_SLOTS];
    logic [SLOT_W-1:0]    stk_slot_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] stk_pend_mem [NUM_SLOTS];

    logic [6:0]           node_x;
    logic [6:0]           target_x;
    logic [SLOT_W-1:0]    node_addr;
    logic [SLOT_W-1:0]    target_addr;
    logic [NUM_SLOTS-1:0] node_bit;
    logic [NUM_SLOTS-1:0] target_bit;
    logic [NUM_SLOTS-1:0] row_data;
    logic [NUM_SLOTS-1:0] v_bit;
    logic [SLOT_W-1:0]    v_idx;
    logic [SLOT_W-1:0]    rd_addr;
    logic [DEPTH_W-1:0]   depth_m1;
    logic [DEPTH_W-1:0]   depth_m2;
    logic                 mat_we;
    logic [SLOT_W-1:0]    mat_wa;
    logic [NUM_SLOTS-1:0] mat_wd;

    assign node_x      = {2'b00, item_reg.node};
    assign target_x    = {2'b00, item_reg.target};
    assign node_addr   = node_x[SLOT_W-1:0];
    assign target_addr = target_x[SLOT_W-1:0];
    assign node_bit    = ONE_ROW << node_addr;
    assign target_bit  = ONE_ROW << target_addr;
    assign row_data    = mat_qv_reg ? mat_q_reg : '0;
    assign v_bit       = cur_pend_reg & ((~cur_pend_reg) + ONE_ROW);
    assign depth_m1    = depth_reg - DEPTH_W'(1);
    assign depth_m2    = depth_reg - DEPTH_W'(2);

    // lowest pending neighbour
    always_comb
    begin
        v_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (cur_pend_reg[i])
            begin
                v_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        unique case (cmd.rd_src)
            wfgdd_pkg::RD_NODE:  rd_addr = node_addr;
            wfgdd_pkg::RD_SWEEP: rd_addr = sweep_reg;
            wfgdd_pkg::RD_NEXT:  rd_addr = v_idx;
            default:             rd_addr = node_addr;
        endcase
    end

    always_comb
    begin
        mat_we = cmd.add_wr || cmd.rem_wr;
        if (cmd.add_wr)
        begin
            mat_wa = node_addr;
            mat_wd = row_data | target_bit;
        end
        else
        begin
            mat_wa = sweep_reg;
            mat_wd = (sweep_reg == node_addr) ? '0 : (row_data & ~node_bit);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_wa] <= mat_wd;
        end
        mat_q_reg <= mat_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stk_slot_mem[depth_m1[SLOT_W-1:0]] <= cur_slot_reg;
            stk_pend_mem[depth_m1[SLOT_W-1:0]] <= cur_pend_reg & ~v_bit;
        end
        stk_slot_q_reg <= stk_slot_mem[depth_m2[SLOT_W-1:0]];
        stk_pend_q_reg <= stk_pend_mem[depth_m2[SLOT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.load_top)
        begin
            cur_slot_reg <= rd_addr_reg;
            cur_pend_reg <= row_data;
        end
        else if (cmd.pop_load)
        begin
            cur_slot_reg <= stk_slot_q_reg;
            cur_pend_reg <= stk_pend_q_reg;
        end
        else if (cmd.skip)
        begin
            cur_pend_reg <= cur_pend_reg & ~v_bit;
        end
        if (cmd.res_load)
        begin
            out_data_reg.deadlock  <= found_reg;
            out_data_reg.done_kind <= item_reg.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            sweep_reg     <= '0;
            visited_reg   <= '0;
            onstack_reg   <= '0;
            row_valid_reg <= '0;
            depth_reg     <= '0;
            mat_qv_reg    <= 1'b0;
        end
        else
        begin
            mat_qv_reg <= row_valid_reg[rd_addr];
            if (mat_we)
            begin
                row_valid_reg[mat_wa] <= 1'b1;
            end
            if (cmd.load_item)
            begin
                found_reg <= 1'b0;
                sweep_reg <= '0;
            end
            else if (cmd.rem_wr)
            begin
                sweep_reg <= sweep_reg + SLOT_W'(1);
            end
            else if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.search_init)
            begin
                visited_reg <= '0;
                onstack_reg <= '0;
                depth_reg   <= '0;
            end
            else if (cmd.load_top)
            begin
                visited_reg <= visited_reg | (ONE_ROW << rd_addr_reg);
                onstack_reg <= onstack_reg | (ONE_ROW << rd_addr_reg);
                depth_reg   <= depth_reg + DEPTH_W'(1);
            end
            else if (cmd.pop)
            begin
                onstack_reg <= onstack_reg & ~(ONE_ROW << cur_slot_reg);
                depth_reg   <= depth_m1;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status.kind       = item_reg.kind;
        status.node_ok    = node_x < SLOTS_L;
        status.target_ok  = target_x < SLOTS_L;
        status.self_edge  = item_reg.node == item_reg.target;
        status.sweep_last = sweep_reg == SLOT_W'(NUM_SLOTS - 1);
        status.pend_zero  = cur_pend_reg == '0;
        status.depth_one  = depth_reg == DEPTH_W'(1);
        status.v_on_stack = |(onstack_reg & v_bit);
        status.v_visited  = |(visited_reg & v_bit);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/wait_for_graph_deadlock_detector.sv
// wait_for_graph_deadlock_detector: top level, sequencer plus datapath
// depends on wfgdd_pkg, wfgdd_ctrl, wfgdd_dp
//
//   channel  signals                       payload
//   in       in_valid / in_ready           in_data  (kind, node, target)
//   out      out_valid / out_ready         out_data (deadlock, done_kind)
//
// one item at a time; in_ready is high only while the sequencer is idle
// add: read-modify-write of the node's row; remove: read-modify-write sweep of the matrix
// check: depth-first search over the pending edges, taken one at a time, with pushes and
// pops of the search stack; its run time is set by the single matrix read port
// reset empties the graph at once through per-row valid flags, no clearing pass
// a held result stalls only the end of the next item, never its acceptance
module wait_for_graph_deadlock_detector #(
    parameter int NUM_SLOTS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wfgdd_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wfgdd_pkg::out_item_t out_data
);

    wfgdd_pkg::dp_cmd_t    cmd;
    wfgdd_pkg::dp_status_t status;

    wfgdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .status   (status),
        .cmd      (cmd)
    );

    wfgdd_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

>>> design/wfgdd_chk.sv
// wfgdd_chk: port-level checks on the deadlock detector, bound to the top level
// depends on wfgdd_pkg and wait_for_graph_deadlock_detector
module wfgdd_chk
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input wfgdd_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input wfgdd_pkg::out_item_t out_data
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // only a check can report a deadlock
    a_dl_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.deadlock |-> out_data.done_kind == wfgdd_pkg::KIND_CHECK)
        else $error("deadlock flagged on a non-check item");

    // busy after a transfer in
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // no result appears in the cycle right after a transfer in
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind wait_for_graph_deadlock_detector wfgdd_chk u_chk (.*);
